FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, operation codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int SPQ_DEPTH        = 16;
  localparam int SPQ_PRIO_BITS    = 16;
  localparam int SPQ_PAYLOAD_BITS = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_op_t;

endpackage

`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded priority queue kept in a row of cells sorted by descending priority.
// ----------------------------------------------------------------------------
// The queue takes one operation per clock cycle (insert, remove head, clear)
// and returns one result per operation, in the cycle after the input transfer:
// every cell compares its priority with the new one in parallel and shifts
// with its neighbors in the same cycle, so the cell row sets a fixed rate of
// one item per cycle as long as results are taken; the result register holds
// the input back only while a result waits. Equal priorities leave in arrival
// order. An insert into a full queue and a removal from an empty queue leave
// the queue unchanged and are reported in the status field.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH        = SPQ_DEPTH,
  parameter int PRIO_BITS    = SPQ_PRIO_BITS,
  parameter int PAYLOAD_BITS = SPQ_PAYLOAD_BITS,
  localparam int CNT_W       = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              kind_i,
  input  wire logic [PRIO_BITS-1:0]    priority_req_i,
  input  wire logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [PAYLOAD_BITS-1:0]      head_payload_o,
  output logic [PRIO_BITS-1:0]         head_priority_o,
  output logic [CNT_W-1:0]             entry_count_o,
  output logic                         is_empty_o,
  output logic [1:0]                   status_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] count_q,     count_d;
  logic [1:0]       status_q,    status_d;
  logic             accept;
  logic             is_full;
  logic             is_zero;
  spq_op_t          op;

  logic [PRIO_BITS-1:0]    cell_prio    [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
  logic                    cell_keep    [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == FULL_CNT);
  assign is_zero    = (count_q == '0);

  always_comb begin
    op          = '0;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_DONE;
      case (kind_i)
        KIND_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            op.ins  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (is_zero) begin
            status_d = ST_EMPTY;
          end else begin
            op.rem  = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        KIND_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= ST_DONE;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      status_q    <= status_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

    logic                    left_keep;
    logic [PRIO_BITS-1:0]    left_prio;
    logic [PAYLOAD_BITS-1:0] left_payload;
    logic [PRIO_BITS-1:0]    right_prio;
    logic [PAYLOAD_BITS-1:0] right_payload;

    if (i == 0) begin : g_first
      assign left_keep    = 1'b1;
      assign left_prio    = priority_req_i;
      assign left_payload = payload_i;
    end else begin : g_inner
      assign left_keep    = cell_keep[i-1];
      assign left_prio    = cell_prio[i-1];
      assign left_payload = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_prio    = cell_prio[i];
      assign right_payload = cell_payload[i];
    end else begin : g_mid
      assign right_prio    = cell_prio[i+1];
      assign right_payload = cell_payload[i+1];
    end

    spq_cell #(
      .PRIO_BITS    (PRIO_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .op_i            (op),
      .occupied_i      (count_q > IDX),
      .new_prio_i      (priority_req_i),
      .new_payload_i   (payload_i),
      .left_keep_i     (left_keep),
      .left_prio_i     (left_prio),
      .left_payload_i  (left_payload),
      .right_prio_i    (right_prio),
      .right_payload_i (right_payload),
      .keep_o          (cell_keep[i]),
      .prio_o          (cell_prio[i]),
      .payload_o       (cell_payload[i])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign head_payload_o  = is_zero ? '0 : cell_payload[0];
  assign head_priority_o = is_zero ? '0 : cell_prio[0];
  assign entry_count_o   = count_q;
  assign is_empty_o      = is_zero;
  assign status_o        = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("Entry count exceeds the queue depth.");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind_i == KIND_INSERT) && !is_full |=>
      (count_q == $past(count_q) + 1'b1) && (status_q == ST_DONE))
    else $error("Accepted insert did not add an entry.");

  a_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind_i == KIND_REMOVE) && is_zero |=>
      (count_q == '0) && (status_q == ST_EMPTY))
    else $error("Removal from an empty queue was not flagged.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(count_q) && $stable(status_q))
    else $error("Queue state changed while a result was stalled.");
`endif

endmodule

`default_nettype wire

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIO_BITS    = SPQ_PRIO_BITS,
  parameter int PAYLOAD_BITS = SPQ_PAYLOAD_BITS
) (
  input  wire logic                    clk_i,
  input  wire spq_op_t                 op_i,
  input  wire logic                    occupied_i,
  input  wire logic [PRIO_BITS-1:0]    new_prio_i,
  input  wire logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  wire logic                    left_keep_i,
  input  wire logic [PRIO_BITS-1:0]    left_prio_i,
  input  wire logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  wire logic [PRIO_BITS-1:0]    right_prio_i,
  input  wire logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic                         keep_o,
  output logic [PRIO_BITS-1:0]         prio_o,
  output logic [PAYLOAD_BITS-1:0]      payload_o
);

  logic [PRIO_BITS-1:0]    prio_q,    prio_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;

  assign keep_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    prio_d    = prio_q;
    payload_d = payload_q;
    if (op_i.ins && !keep_o) begin
      if (left_keep_i) begin
        prio_d    = new_prio_i;
        payload_d = new_payload_i;
      end else begin
        prio_d    = left_prio_i;
        payload_d = left_payload_i;
      end
    end else if (op_i.rem) begin
      prio_d    = right_prio_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert, remove, clear and unused operations into the queue through
// its input handshake, with random gaps on the input side and random stalls
// on the result side. A behavioral copy of the sorted entry list predicts the
// head entry, entry count, empty flag and status of every result, and each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import spq_pkg::*;

  localparam int CNT_W = $clog2(SPQ_DEPTH + 1);
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef logic [SPQ_PRIO_BITS-1:0] prio_t;
  typedef logic [SPQ_PAYLOAD_BITS-1:0] data_t;

  typedef struct {
    data_t            payload;
    prio_t            prio;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic [1:0]       status;
  } head_report_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [1:0]                  kind_i;
  prio_t                       priority_req_i;
  data_t                       payload_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  data_t                       head_payload_o;
  prio_t                       head_priority_o;
  logic [CNT_W-1:0]            entry_count_o;
  logic                        is_empty_o;
  logic [1:0]                  status_o;

  prio_t        held_prio [SPQ_DEPTH];
  data_t        held_data [SPQ_DEPTH];
  int           held_count;
  head_report_t pending_heads [$];
  int           failures;
  bit           gaps_on;
  bit           stalls_on;

  sorted_priority_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .priority_req_i (priority_req_i),
    .payload_i      (payload_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .head_payload_o (head_payload_o),
    .head_priority_o(head_priority_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #1_000_000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

  function automatic head_report_t apply_queue_op(input logic [1:0] kind, input prio_t prio,
                                                  input data_t data);
    head_report_t rep;
    int pos;
    int i;
    rep.status = ST_DONE;
    case (kind)
      KIND_INSERT: begin
        if (held_count >= SPQ_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] >= prio) pos++;
          for (i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i-1];
            held_data[i] = held_data[i-1];
          end
          held_prio[pos] = prio;
          held_data[pos] = data;
          held_count++;
        end
      end
      KIND_REMOVE: begin
        if (held_count == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          for (i = 1; i < held_count; i++) begin
            held_prio[i-1] = held_prio[i];
            held_data[i-1] = held_data[i];
          end
          held_count--;
        end
      end
      KIND_CLEAR: begin
        held_count = 0;
      end
      default: begin
      end
    endcase
    rep.payload = (held_count > 0) ? held_data[0] : '0;
    rep.prio    = (held_count > 0) ? held_prio[0] : '0;
    rep.empty   = (held_count == 0);
    rep.count   = held_count[CNT_W-1:0];
    return rep;
  endfunction

  task automatic send_op(input logic [1:0] kind, input prio_t prio, input data_t data);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    priority_req_i <= prio;
    payload_i      <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_heads.push_back(apply_queue_op(kind, prio, data));
  endtask

  task automatic send_random_op(input int insert_pct);
    logic [1:0] kind;
    prio_t      prio;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) kind = KIND_NOP;
    else if (pick < 5) kind = KIND_CLEAR;
    else if ($urandom_range(0, 99) < insert_pct) kind = KIND_INSERT;
    else kind = KIND_REMOVE;
    pick = $urandom_range(0, 9);
    if (pick < 5) prio = prio_t'($urandom_range(0, 3));
    else if (pick == 5) prio = '1;
    else if (pick == 6) prio = '0;
    else prio = prio_t'($urandom);
    send_op(kind, prio, data_t'($urandom));
  endtask

  always @(posedge clk_i) begin
    head_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_heads.size() == 0) begin
        $error("result transfer with no prediction waiting");
        failures++;
      end else begin
        want = pending_heads.pop_front();
        if (head_payload_o !== want.payload) begin
          $error("head_payload: expected %h, actual %h", want.payload, head_payload_o);
          failures++;
        end
        if (head_priority_o !== want.prio) begin
          $error("head_priority: expected %h, actual %h", want.prio, head_priority_o);
          failures++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
          failures++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty: expected %b, actual %b", want.empty, is_empty_o);
          failures++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          failures++;
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_empty_queue();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_op(KIND_REMOVE, '1, '1);
    send_op(KIND_CLEAR, '0, '0);
    send_op(KIND_NOP, 16'h1234, 32'h89ab_cdef);
  endtask

  task automatic test_field_extremes();
    send_op(KIND_INSERT, '0, '0);
    send_op(KIND_INSERT, '1, '1);
    send_op(KIND_INSERT, '1, 32'h5a5a_5a5a);
    send_op(KIND_NOP, '1, '1);
    send_op(KIND_REMOVE, '0, '0);
    send_op(KIND_REMOVE, '0, '0);
    send_op(KIND_REMOVE, '0, '0);
  endtask

  // Few distinct priorities so that ties decide most positions.
  task automatic test_full_queue();
    int n;
    for (n = 0; n < SPQ_DEPTH; n++) send_op(KIND_INSERT, prio_t'(n % 3), data_t'(n));
    send_op(KIND_INSERT, '1, '1);
    send_op(KIND_CLEAR, '0, '0);
  endtask

  task automatic test_random_traffic(input int segments);
    int seg;
    int n;
    int insert_pct;
    for (seg = 0; seg < segments; seg++) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 20;
        1: insert_pct = 50;
        2: insert_pct = 75;
        default: insert_pct = 95;
      endcase
      gaps_on   = ($urandom_range(0, 2) != 0);
      stalls_on = ($urandom_range(0, 2) != 0);
      for (n = 0; n < 50; n++) send_random_op(insert_pct);
    end
  endtask

  task automatic test_steady_stream(input int items);
    int n;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (n = 0; n < items; n++) send_random_op((n / 20) % 2 == 0 ? 85 : 30);
  endtask

  initial begin
    int waited;
    failures       = 0;
    held_count     = 0;
    gaps_on        = 1'b0;
    stalls_on      = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_INSERT;
    priority_req_i = '0;
    payload_i      = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_field_extremes();
    test_full_queue();
    test_random_traffic(13);
    test_steady_stream(100);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_heads.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_heads.size() != 0) begin
      $error("%0d predicted results never arrived", pending_heads.size());
      failures++;
    end
    if (failures == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
